FILE: hdl/psbr_pkg.sv
// ----------------------------------------------------------------------------
// psbr_pkg
// Shared widths, field offsets, axis codes and controller/datapath structs
// for the point set bounds and radius block.
// ----------------------------------------------------------------------------
package psbr_pkg;

    // Coordinate format is fixed by the stream fields
    localparam int COORD_BITS = 24;
    localparam int AXES       = 3;

    // Second-pass arithmetic widths
    localparam int D_W    = COORD_BITS + 2;   // 2*p - (min+max), signed
    localparam int MAG_W  = COORD_BITS + 1;   // |2*p - (min+max)|
    localparam int SQ_W   = 2 * MAG_W;        // one squared term
    localparam int SUM_W  = SQ_W + 2;         // sum of three squares
    localparam int ROOT_W = SUM_W / 2;        // floor square root
    localparam int CEN_W  = COORD_BITS + 1;   // min + max

    // Slave side word layout
    localparam int S_DATA_W   = AXES * COORD_BITS;
    localparam int S_USER_W   = 2;
    localparam int S_USER_HAS = 0;
    localparam int S_USER_BAD = 1;

    // Master side word layout
    localparam int O_MIN       = 0;
    localparam int O_MAX       = O_MIN + COORD_BITS;
    localparam int O_CEN       = O_MAX + COORD_BITS;
    localparam int O_EXT       = O_CEN + CEN_W;
    localparam int O_LRG       = O_EXT + COORD_BITS;
    localparam int O_RAD       = O_LRG + COORD_BITS;
    localparam int M_FIELD_W   = O_RAD + ROOT_W;
    localparam int M_DATA_W    = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_USER_W    = 3;
    localparam int M_USER_AXIS = 0;
    localparam int M_USER_OK   = 2;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic load_en;     // take points from the slave side
        logic pass_run;    // issue one store read this cycle
        logic root_start;  // launch the square root on the final maximum
        logic emit;        // push per-axis results to the output register
    } psbr_cmd_t;

    typedef struct packed {
        logic set_ok;      // set nonempty and not spoiled
        logic pass_last;   // read of the last stored point issues this cycle
        logic pipe_busy;   // distance pipeline still holds points
        logic root_done;   // square root result ready
        logic emit_done;   // z result loaded, set state cleared
    } psbr_stat_t;

endpackage

FILE: hdl/point_set_bounds_and_radius.sv
// Loading: one point word per cycle, N words per set, the last one flagged by tlast.
// After the last word: a check state, N store reads (one memory read port), a pipeline
// drain, the root launch, the square root (26 steps, then done) and 3 result words.
// An empty or spoiled set skips the pass and the root: the check state, then 3 words.
// Reset clears all control and set state at once; the point store is not cleared.
// ----------------------------------------------------------------------------
// point_set_bounds_and_radius
// Axis-aligned bounding box and bounding sphere of a streamed 3D point set.
// ----------------------------------------------------------------------------
module point_set_bounds_and_radius
#(
    parameter int MAX_POINTS = 4096
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    // Point words
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [psbr_pkg::S_DATA_W-1:0]  s_axis_tdata,  // x_coord, y_coord, z_coord
    input  logic [psbr_pkg::S_USER_W-1:0]  s_axis_tuser,  // has_point, point_bad
    input  logic                           s_axis_tlast,  // last_point

    // Result words, one per axis
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // min_value, max_value, center_doubled, extent, largest_extent, radius_doubled, pad
    output logic [psbr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic [psbr_pkg::M_USER_W-1:0]  m_axis_tuser,  // axis[1:0], valid_res
    output logic                           m_axis_tlast   // last_result
);

    psbr_pkg::psbr_cmd_t  cmd;
    psbr_pkg::psbr_stat_t stat;

    // Sequencer: ready only while loading points
    psbr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store, bounds, distance pass, root and output register
    psbr_dpath
    #(
        .MAX_POINTS (MAX_POINTS)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    // The output register holds a finished word while the next set loads
    assign s_axis_tready = cmd.load_en;

endmodule

FILE: hdl/psbr_isqrt.sv
// ----------------------------------------------------------------------------
// psbr_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module psbr_isqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [psbr_pkg::SUM_W-1:0]   radicand,
    output logic                         done,
    output logic [psbr_pkg::ROOT_W-1:0]  root
);

    localparam int RW     = psbr_pkg::ROOT_W;
    localparam int SW     = psbr_pkg::SUM_W;
    localparam int STEP_W = $clog2(RW);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SW-1:0]     rad_reg;
    logic [RW:0]       rem_reg;
    logic [RW-1:0]     root_reg;

    logic [RW+2:0]     rem_shift;
    logic [RW+2:0]     trial;
    logic [RW+2:0]     rem_sub;
    logic              fits;

    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[SW-1:SW-2]};
        trial     = {1'b0, root_reg, 2'b01};
        rem_sub   = rem_shift - trial;
        fits      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (fits)
            begin
                rem_reg  <= rem_sub[RW:0];
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[RW:0];
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hdl/psbr_dpath.sv
// ----------------------------------------------------------------------------
// psbr_dpath
// Point store, running bounds, distance pipeline, square root and result
// output register.
// ----------------------------------------------------------------------------
module psbr_dpath
#(
    parameter int MAX_POINTS = 4096
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  psbr_pkg::psbr_cmd_t            cmd,
    output psbr_pkg::psbr_stat_t           stat,
    input  logic                           in_valid,
    input  logic [psbr_pkg::S_DATA_W-1:0]  in_data,
    input  logic [psbr_pkg::S_USER_W-1:0]  in_user,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [psbr_pkg::M_DATA_W-1:0]  out_data,
    output logic [psbr_pkg::M_USER_W-1:0]  out_user,
    output logic                           out_last
);

    localparam int CB     = psbr_pkg::COORD_BITS;
    localparam int NA     = psbr_pkg::AXES;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // Point store
    logic [psbr_pkg::S_DATA_W-1:0] mem [MAX_POINTS];
    logic [psbr_pkg::S_DATA_W-1:0] rd_data_reg;

    // Set state
    logic [CNT_W-1:0]      count_reg;
    logic                  spoiled_reg;
    logic signed [CB-1:0]  min_reg [NA];
    logic signed [CB-1:0]  max_reg [NA];
    logic [ADDR_W-1:0]     addr_reg;
    logic [psbr_pkg::SUM_W-1:0] maxsq_reg;

    // Distance pipeline
    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [psbr_pkg::MAG_W-1:0]  mag_reg  [NA];
    logic [psbr_pkg::MAG_W-1:0]  mag_next [NA];
    logic [psbr_pkg::SQ_W-1:0]   sq_reg   [NA];
    logic [psbr_pkg::SUM_W-1:0]  sum_reg;

    // Results
    logic [CB-1:0]               largest_reg;
    logic [CB-1:0]               largest_next;
    logic [CB-1:0]               ext [NA];
    logic [1:0]                  axis_reg;
    logic                        out_valid_reg;
    logic [psbr_pkg::M_DATA_W-1:0] out_data_reg;
    logic [psbr_pkg::M_DATA_W-1:0] out_data_next;
    logic [psbr_pkg::M_USER_W-1:0] out_user_reg;
    logic                        out_last_reg;
    logic [psbr_pkg::ROOT_W-1:0] root;
    logic                        root_done;

    logic signed [CB-1:0]  in_c [NA];
    logic signed [CB-1:0]  rd_c [NA];
    logic                  accept, take_pt, full, store_pt;
    logic                  set_ok, out_free, emit_fire, emit_done;
    logic signed [CB-1:0]  sel_min, sel_max;
    logic signed [psbr_pkg::CEN_W-1:0] sel_cen, sel_diff;

    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            in_c[a] = in_data[a*CB +: CB];
            rd_c[a] = rd_data_reg[a*CB +: CB];
        end
    end

    assign accept    = cmd.load_en && in_valid;
    assign take_pt   = accept && in_user[psbr_pkg::S_USER_HAS];
    assign full      = (count_reg == CNT_W'(MAX_POINTS));
    assign store_pt  = take_pt && !full;
    assign set_ok    = (count_reg != '0) && !spoiled_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = cmd.emit && out_free;
    assign emit_done = emit_fire && (axis_reg == psbr_pkg::AXIS_Z);

    always_ff @(posedge clk)
    begin
        if (store_pt)
        begin
            mem[count_reg[ADDR_W-1:0]] <= in_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            spoiled_reg   <= 1'b0;
            addr_reg      <= '0;
            maxsq_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            axis_reg      <= psbr_pkg::AXIS_X;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < NA; a++)
            begin
                min_reg[a] <= '0;
                max_reg[a] <= '0;
            end
        end
        else
        begin
            v1_reg <= cmd.pass_run;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            if (emit_done)
            begin
                count_reg   <= '0;
                spoiled_reg <= 1'b0;
                addr_reg    <= '0;
                maxsq_reg   <= '0;
                for (int a = 0; a < NA; a++)
                begin
                    min_reg[a] <= '0;
                    max_reg[a] <= '0;
                end
            end
            else
            begin
                if (store_pt)
                begin
                    count_reg <= count_reg + 1'b1;
                    for (int a = 0; a < NA; a++)
                    begin
                        if ((count_reg == '0) || (in_c[a] < min_reg[a]))
                        begin
                            min_reg[a] <= in_c[a];
                        end
                        if ((count_reg == '0) || (in_c[a] > max_reg[a]))
                        begin
                            max_reg[a] <= in_c[a];
                        end
                    end
                end
                if (take_pt && (in_user[psbr_pkg::S_USER_BAD] || full))
                begin
                    spoiled_reg <= 1'b1;
                end
                if (cmd.pass_run)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
                if (v4_reg && (sum_reg > maxsq_reg))
                begin
                    maxsq_reg <= sum_reg;
                end
            end

            if (emit_fire)
            begin
                axis_reg <= emit_done ? psbr_pkg::AXIS_X : axis_reg + 2'd1;
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Doubled distance from the center, per axis
    always_comb
    begin
        logic signed [psbr_pkg::D_W-1:0] cen;
        logic signed [psbr_pkg::D_W-1:0] dd;
        logic [psbr_pkg::D_W-1:0]        ad;
        for (int a = 0; a < NA; a++)
        begin
            cen = psbr_pkg::D_W'(min_reg[a]) + psbr_pkg::D_W'(max_reg[a]);
            dd  = (psbr_pkg::D_W'(rd_c[a]) <<< 1) - cen;
            ad  = dd[psbr_pkg::D_W-1] ? -dd : dd;
            mag_next[a] = ad[psbr_pkg::MAG_W-1:0];
        end
    end

    // Extents and the largest of them
    always_comb
    begin
        logic signed [psbr_pkg::CEN_W-1:0] diff;
        for (int a = 0; a < NA; a++)
        begin
            diff   = psbr_pkg::CEN_W'(max_reg[a]) - psbr_pkg::CEN_W'(min_reg[a]);
            ext[a] = diff[CB-1:0];
        end
        largest_next = ext[0];
        for (int a = 1; a < NA; a++)
        begin
            if (ext[a] > largest_next)
            begin
                largest_next = ext[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NA; a++)
        begin
            mag_reg[a] <= mag_next[a];
            sq_reg[a]  <= psbr_pkg::SQ_W'(mag_reg[a]) * psbr_pkg::SQ_W'(mag_reg[a]);
        end
        sum_reg <= psbr_pkg::SUM_W'(sq_reg[0]) + psbr_pkg::SUM_W'(sq_reg[1])
                 + psbr_pkg::SUM_W'(sq_reg[2]);
        largest_reg <= largest_next;
    end

    psbr_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (maxsq_reg),
        .done     (root_done),
        .root     (root)
    );

    // Result word for the current axis
    always_comb
    begin
        case (axis_reg)
            psbr_pkg::AXIS_X:
            begin
                sel_min = min_reg[0];
                sel_max = max_reg[0];
            end
            psbr_pkg::AXIS_Y:
            begin
                sel_min = min_reg[1];
                sel_max = max_reg[1];
            end
            default:
            begin
                sel_min = min_reg[2];
                sel_max = max_reg[2];
            end
        endcase
        sel_cen  = psbr_pkg::CEN_W'(sel_min) + psbr_pkg::CEN_W'(sel_max);
        sel_diff = psbr_pkg::CEN_W'(sel_max) - psbr_pkg::CEN_W'(sel_min);

        out_data_next = '0;
        if (set_ok)
        begin
            out_data_next[psbr_pkg::O_MIN +: CB]              = sel_min;
            out_data_next[psbr_pkg::O_MAX +: CB]              = sel_max;
            out_data_next[psbr_pkg::O_CEN +: psbr_pkg::CEN_W] = sel_cen;
            out_data_next[psbr_pkg::O_EXT +: CB]              = sel_diff[CB-1:0];
            out_data_next[psbr_pkg::O_LRG +: CB]              = largest_reg;
            out_data_next[psbr_pkg::O_RAD +: psbr_pkg::ROOT_W] = root;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= {set_ok, axis_reg};
            out_last_reg <= (axis_reg == psbr_pkg::AXIS_Z);
        end
    end

    always_comb
    begin
        stat.set_ok    = set_ok;
        stat.pass_last = cmd.pass_run && (CNT_W'(addr_reg) == (count_reg - 1'b1));
        stat.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
        stat.root_done = root_done;
        stat.emit_done = emit_done;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: hdl/psbr_ctrl.sv
// ----------------------------------------------------------------------------
// psbr_ctrl
// Sequencer: load points, run the distance pass, take the root, emit.
// ----------------------------------------------------------------------------
module psbr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    input  psbr_pkg::psbr_stat_t stat,
    output psbr_pkg::psbr_cmd_t  cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_PASS  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load_en    = 1'b0;
        cmd.pass_run   = 1'b0;
        cmd.root_start = 1'b0;
        cmd.emit       = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (in_valid && in_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.set_ok ? S_PASS : S_EMIT;
            end
            S_PASS:
            begin
                cmd.pass_run = 1'b1;
                if (stat.pass_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.root_start = 1'b1;
                    state_next     = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (stat.root_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.emit_done)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/psbr_checker.sv
// ----------------------------------------------------------------------------
// psbr_checker
// Port-level checks on the result stream of the bounds and radius block.
// ----------------------------------------------------------------------------
module psbr_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [psbr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic [psbr_pkg::M_USER_W-1:0]  m_axis_tuser,
    input  logic                           m_axis_tlast
);

    localparam int CB = psbr_pkg::COORD_BITS;

    // Only the z word closes a run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast
            |-> m_axis_tuser[psbr_pkg::M_USER_AXIS +: 2] == psbr_pkg::AXIS_Z)
    else $error("result tlast on a word that is not the z axis");

    // An invalid set reports all-zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[psbr_pkg::M_USER_OK] |-> m_axis_tdata == '0)
    else $error("invalid result word carries nonzero values");

    // Extent is max minus min
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[psbr_pkg::O_EXT +: CB]
            == CB'(m_axis_tdata[psbr_pkg::O_MAX +: CB] - m_axis_tdata[psbr_pkg::O_MIN +: CB]))
    else $error("extent does not match bounds");

    // Largest extent covers this axis
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[psbr_pkg::O_LRG +: CB]
            >= m_axis_tdata[psbr_pkg::O_EXT +: CB])
    else $error("largest extent below axis extent");

    // Stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind point_set_bounds_and_radius psbr_checker u_psbr_checker (.*);
